[rtl/paper_tape_block_loader_assert.svh]
// Assertion macros shared by the paper tape block loader modules.
`ifndef PAPER_TAPE_BLOCK_LOADER_ASSERT_SVH
`define PAPER_TAPE_BLOCK_LOADER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define PTBL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define PTBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ptbl_pkg.sv]
// Types and constants shared by the paper tape block loader modules.
package ptbl_pkg;

	localparam int LOADER_WORDS_DEFAULT = 65;
	localparam int QUEUE_DEPTH_DEFAULT  = 4;

	localparam logic [2:0]  NIBBLE_TAG    = 3'b100;
	localparam logic [15:0] END_ADDRESS   = 16'o177777;
	localparam logic [15:0] START_ADDRESS = 16'o077713;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_COUNT,
		PH_ADDR,
		PH_DATA,
		PH_CSUM
	} phase_t;

	typedef enum logic [1:0] {
		EV_WRITE = 2'd0,
		EV_DONE  = 2'd1,
		EV_CSUM  = 2'd2,
		EV_EOT   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		TK_ADDR,
		TK_DATA,
		TK_CSUM,
		TK_DONE,
		TK_EOT
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] value;
	} token_t;

endpackage

[rtl/ptbl_fifo.sv]
// Small token queue between the tape parser and the event generator.
module ptbl_fifo
	import ptbl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_tok,
	input  logic   pop,
	output token_t rd_tok,
	output logic   not_empty,
	output logic   full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign rd_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "paper_tape_block_loader_assert.svh"

	`PTBL_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "token queue overflow")
	`PTBL_ASSERT_ALWAYS(a_no_underflow, !(pop && !not_empty), "token queue underflow")

endmodule

[rtl/ptbl_front.sv]
// Tape parser: assembles nibbles into words and tracks the block structure.
module ptbl_front
	import ptbl_pkg::*;
#(
	parameter int LOADER_WORDS = LOADER_WORDS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] tape_char,
	input  logic       end_of_tape,
	output logic       push,
	output token_t     push_tok
);

	phase_t       phase_q, phase_d;
	logic [1:0]   nib_q, nib_d;
	logic [11:0]  asm_q, asm_d;
	logic [7:0]   rem_q, rem_d;
	logic         done_q, done_d;

	logic [15:0]  word;
	logic         word_done;
	logic         is_nibble;
	logic         live;

	assign word      = {asm_q, tape_char[3:0]};
	assign word_done = (phase_q == PH_COUNT) ? (nib_q == 2'd1) : (nib_q == 2'd3);
	assign is_nibble = (tape_char[6:4] == NIBBLE_TAG);
	assign live      = accept && !done_q;

	always_comb begin
		phase_d = phase_q;
		nib_d   = nib_q;
		asm_d   = asm_q;
		rem_d   = rem_q;
		done_d  = done_q;
		if (live) begin
			if (end_of_tape) begin
				done_d = 1'b1;
			end else if (is_nibble) begin
				if (!word_done) begin
					asm_d = word[11:0];
					nib_d = nib_q + 1'b1;
				end else begin
					asm_d = '0;
					nib_d = '0;
					case (phase_q)
						PH_SKIP: begin
							rem_d = rem_q - 1'b1;
							if (rem_q == 8'd1) begin
								phase_d = PH_COUNT;
							end
						end
						PH_COUNT: begin
							rem_d   = word[7:0];
							phase_d = PH_ADDR;
						end
						PH_ADDR: begin
							if (word == END_ADDRESS) begin
								done_d = 1'b1;
							end else begin
								phase_d = (rem_q == '0) ? PH_CSUM : PH_DATA;
							end
						end
						PH_DATA: begin
							rem_d = rem_q - 1'b1;
							if (rem_q == 8'd1) begin
								phase_d = PH_CSUM;
							end
						end
						PH_CSUM: begin
							phase_d = PH_COUNT;
						end
						default: begin
							phase_d = PH_COUNT;
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		push           = 1'b0;
		push_tok.kind  = TK_EOT;
		push_tok.value = word;
		if (live) begin
			if (end_of_tape) begin
				push = 1'b1;
			end else if (is_nibble && word_done) begin
				case (phase_q)
					PH_ADDR: begin
						push          = 1'b1;
						push_tok.kind = (word == END_ADDRESS) ? TK_DONE : TK_ADDR;
					end
					PH_DATA: begin
						push          = 1'b1;
						push_tok.kind = TK_DATA;
					end
					PH_CSUM: begin
						push          = 1'b1;
						push_tok.kind = TK_CSUM;
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= (LOADER_WORDS == 0) ? PH_COUNT : PH_SKIP;
			nib_q   <= '0;
			asm_q   <= '0;
			rem_q   <= 8'(LOADER_WORDS);
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			asm_q   <= asm_d;
			rem_q   <= rem_d;
			done_q  <= done_d;
		end
	end

`include "paper_tape_block_loader_assert.svh"

	`PTBL_ASSERT_ALWAYS(a_front_quiet_when_done, !(done_q && push), "parser pushed after load end")

endmodule

[rtl/ptbl_back.sv]
// Event generator: masks addresses, keeps the block checksum, drives results.
module ptbl_back
	import ptbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  token_t      tok,
	output logic        pop,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output event_t      out_event,
	output logic [15:0] out_address,
	output logic [15:0] out_data
);

	logic [15:0] address_mask_q;
	logic [15:0] load_addr_q, load_addr_d;
	logic [15:0] csum_q, csum_d;
	logic        done_q, done_d;
	logic        out_valid_q;
	event_t      event_q;
	logic [15:0] address_q;
	logic [15:0] data_q;

	logic        emit;
	event_t      ev;
	logic [15:0] addr_o;
	logic [15:0] data_o;
	logic [16:0] sum;

	assign pop = tok_valid && (!out_valid_q || out_ready);
	assign sum = {1'b0, csum_q} + {1'b0, tok.value};

	always_comb begin
		emit        = 1'b0;
		ev          = EV_WRITE;
		addr_o      = '0;
		data_o      = '0;
		load_addr_d = load_addr_q;
		csum_d      = csum_q;
		done_d      = done_q;
		if (pop && !done_q) begin
			case (tok.kind)
				TK_ADDR: begin
					load_addr_d = tok.value;
					csum_d      = '0;
				end
				TK_DATA: begin
					emit        = 1'b1;
					addr_o      = load_addr_q & address_mask_q;
					data_o      = tok.value;
					// End-around carry folds the overflow bit back in.
					csum_d      = sum[15:0] + 16'(sum[16]);
					load_addr_d = load_addr_q + 1'b1;
				end
				TK_CSUM: begin
					if (tok.value != csum_q) begin
						emit   = 1'b1;
						ev     = EV_CSUM;
						data_o = tok.value;
						done_d = 1'b1;
					end
				end
				TK_DONE: begin
					emit   = 1'b1;
					ev     = EV_DONE;
					addr_o = START_ADDRESS & address_mask_q;
					done_d = 1'b1;
				end
				TK_EOT: begin
					emit   = 1'b1;
					ev     = EV_EOT;
					done_d = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_mask_q <= 16'd16383;
			load_addr_q    <= '0;
			csum_q         <= '0;
			done_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				address_mask_q <= cfg_data;
			end
			load_addr_q <= load_addr_d;
			csum_q      <= csum_d;
			done_q      <= done_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			event_q   <= ev;
			address_q <= addr_o;
			data_q    <= data_o;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_event   = event_q;
	assign out_address = address_q;
	assign out_data    = data_q;

`include "paper_tape_block_loader_assert.svh"

	`PTBL_ASSERT_NEXT(a_done_sticks, done_q, done_q, "finished flag cleared without reset")
	`PTBL_ASSERT_NEXT(a_no_result_after_done, done_q && !out_valid_q, !out_valid_q,
		"result produced after load end")

endmodule

[rtl/paper_tape_block_loader.sv]
// Top level of the paper tape block loader.
// The block takes one tape character per clock cycle while the queue has
// room. A parser assembles nibbles into words and follows the block layout,
// then hands address, data, checksum and end tokens through a queue (four
// entries by default) to an event generator that masks addresses, keeps the
// one's-complement checksum and holds each result in an output register. A
// result reaches the output through the queue and the output register; the
// input stalls only when the queue fills because results are not being taken.
// The address mask may be written only while the block is idle.
module paper_tape_block_loader
	import ptbl_pkg::*;
#(
	parameter int LOADER_WORDS = LOADER_WORDS_DEFAULT,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] tape_char
	input  logic        s_tlast,   // end_of_tape
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] event_res, [17:2] address, [33:18] data, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        accept;
	logic        push;
	token_t      push_tok;
	logic        pop;
	token_t      rd_tok;
	logic        not_empty;
	logic        full;
	event_t      out_event;
	logic [15:0] out_address;
	logic [15:0] out_data;

	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	ptbl_front #(
		.LOADER_WORDS(LOADER_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.tape_char  (s_tdata),
		.end_of_tape(s_tlast),
		.push       (push),
		.push_tok   (push_tok)
	);

	ptbl_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.rd_tok   (rd_tok),
		.not_empty(not_empty),
		.full     (full)
	);

	ptbl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (not_empty),
		.tok        (rd_tok),
		.pop        (pop),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_event  (out_event),
		.out_address(out_address),
		.out_data   (out_data)
	);

	assign m_tdata = {6'b0, out_data, out_address, out_event};

endmodule

[tb/paper_tape_block_loader_test.sv]
// Testbench for the paper tape block loader: one full tape load checked against a local predictor.
`timescale 1ns / 1ps
module paper_tape_block_loader_test
	import ptbl_pkg::*;
();

	typedef struct packed {
		event_t      ev;
		logic [15:0] addr;
		logic [15:0] dat;
	} load_event_t;

	localparam int TAPE_ITEMS = 1950;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	paper_tape_block_loader i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Loader state as the predictor tracks it.
	phase_t      ld_phase;
	logic [2:0]  ld_nibbles;
	logic [15:0] ld_assembly;
	logic [7:0]  ld_left;
	logic [15:0] ld_address;
	logic [15:0] ld_sum;
	logic [15:0] ld_mask;
	logic        ld_finished;

	load_event_t pending_events[$];

	int    errors = 0;
	int    items_sent = 0;
	int    writes_seen = 0;
	int    masks_written = 0;
	int    blocks_sent = 0;
	int    send_idle_pct = 9;
	int    recv_idle_pct = 47;
	string ending = "";

	// Characters seen while the loader words are skipped; none of them yields a result.
	logic [7:0] skip_chars [18] = '{
		8'h00, 8'hFF, 8'h7F, 8'h80, 8'h30, 8'h50, 8'h60, 8'h70, 8'h20,
		8'h10, 8'hB0, 8'hF5, 8'h40, 8'hCF, 8'h4F, 8'hC0, 8'h4A, 8'hC5
	};

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[16])
			s = s + 17'd1;
		return s[15:0];
	endfunction

	function automatic bit predict_event(input logic [7:0] c, input logic eot,
			output load_event_t r);
		logic [15:0] word;
		int need;
		r = '0;
		if (ld_finished)
			return 1'b0;
		if (eot) begin
			ld_finished = 1'b1;
			r.ev = EV_EOT;
			return 1'b1;
		end
		if (c[6:4] != NIBBLE_TAG)
			return 1'b0;
		ld_assembly = {ld_assembly[11:0], c[3:0]};
		ld_nibbles = ld_nibbles + 3'd1;
		need = (ld_phase == PH_COUNT) ? 2 : 4;
		if (int'(ld_nibbles) < need)
			return 1'b0;
		word = (need == 2) ? {8'h00, ld_assembly[7:0]} : ld_assembly;
		ld_nibbles = '0;
		ld_assembly = '0;
		case (ld_phase)
			PH_SKIP: begin
				ld_left = ld_left - 8'd1;
				if (ld_left == 0)
					ld_phase = PH_COUNT;
			end
			PH_COUNT: begin
				ld_left = word[7:0];
				ld_phase = PH_ADDR;
			end
			PH_ADDR: begin
				if (word == END_ADDRESS) begin
					ld_finished = 1'b1;
					r.ev = EV_DONE;
					r.addr = START_ADDRESS & ld_mask;
					return 1'b1;
				end
				ld_address = word;
				ld_sum = '0;
				ld_phase = (ld_left == 0) ? PH_CSUM : PH_DATA;
			end
			PH_DATA: begin
				r.ev = EV_WRITE;
				r.addr = ld_address & ld_mask;
				r.dat = word;
				ld_sum = ones_add(ld_sum, word);
				ld_address = ld_address + 16'd1;
				ld_left = ld_left - 8'd1;
				if (ld_left == 0)
					ld_phase = PH_CSUM;
				return 1'b1;
			end
			PH_CSUM: begin
				if (word != ld_sum) begin
					ld_finished = 1'b1;
					r.ev = EV_CSUM;
					r.dat = word;
					return 1'b1;
				end
				ld_phase = PH_COUNT;
			end
			default: ld_phase = PH_COUNT;
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: mismatch, %s", $time, what);
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		load_event_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("result %h with none expected", m_tdata));
			end else begin
				e = pending_events.pop_front();
				if (m_tdata[1:0] !== e.ev)
					report_mismatch($sformatf("event %0d, expected %0d", m_tdata[1:0], e.ev));
				if (m_tdata[17:2] !== e.addr)
					report_mismatch($sformatf("address %h, expected %h", m_tdata[17:2], e.addr));
				if (m_tdata[33:18] !== e.dat)
					report_mismatch($sformatf("data %h, expected %h", m_tdata[33:18], e.dat));
				if (e.ev == EV_WRITE)
					writes_seen++;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// One character transaction; typed_none rows expect no result by construction.
	task automatic send_char(input logic [7:0] c, input logic eot, input bit typed_none);
		load_event_t r;
		bit got;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		got = predict_event(c, eot, r);
		if (got && !typed_none)
			pending_events.push_back(r);
		else if (got)
			report_mismatch("directed row predicted a result");
	endtask

	task automatic send_nibble(input logic [3:0] n);
		logic [7:0] c;
		logic hi;
		// Characters outside the data tag are sprinkled in as tape noise.
		while ($urandom_range(99) < 6) begin
			c = 8'($urandom_range(255));
			if (c[6:4] == NIBBLE_TAG)
				c[5] = 1'b1;
			send_char(c, 1'b0, 1'b0);
		end
		hi = 1'($urandom_range(1));
		send_char({hi, NIBBLE_TAG, n}, 1'b0, 1'b0);
	endtask

	task automatic send_word(input logic [15:0] w, input int nibbles);
		for (int i = nibbles - 1; i >= 0; i--)
			send_nibble(w[4 * i +: 4]);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		// A good checksum leaves no result, so let the pipeline drain as well.
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mask(input logic [15:0] v);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ld_mask = v;
		masks_written++;
	endtask

	function automatic logic [15:0] pick_mask(input int k);
		case (k % 6)
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'h3FFF;
			3: return 16'h00FF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic send_block(input bit bad_sum);
		logic [7:0]  cnt;
		logic [15:0] addr, w, sum;
		int r;
		r = $urandom_range(9);
		if (r == 0)
			cnt = 8'd0;
		else if (r == 9)
			cnt = 8'($urandom_range(40, 13));
		else
			cnt = 8'($urandom_range(12, 1));
		if ($urandom_range(7) == 0)
			addr = 16'hFFF0 + 16'($urandom_range(14));
		else
			addr = 16'($urandom_range(65535));
		if (addr == END_ADDRESS)
			addr = '0;
		sum = '0;
		send_word({8'h00, cnt}, 2);
		send_word(addr, 4);
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(7);
			w = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom_range(65535));
			sum = ones_add(sum, w);
			send_word(w, 4);
		end
		if (bad_sum)
			sum = sum ^ 16'($urandom_range(65535, 1));
		send_word(sum, 4);
		blocks_sent++;
	endtask

	initial begin
		int k, stage, idle_stage, term;
		ld_mask = 16'd16383;
		ld_left = 8'(LOADER_WORDS_DEFAULT);
		ld_phase = (ld_left == 0) ? PH_COUNT : PH_SKIP;
		ld_nibbles = '0;
		ld_assembly = '0;
		ld_address = '0;
		ld_sum = '0;
		ld_finished = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (skip_chars[i])
			send_char(skip_chars[i], 1'b0, 1'b1);
		while (ld_phase == PH_SKIP)
			send_nibble(4'($urandom_range(15)));

		write_mask(pick_mask(0));
		k = 1;
		stage = 0;
		while (items_sent < TAPE_ITEMS) begin
			idle_stage = items_sent * 3 / TAPE_ITEMS;
			if (idle_stage != stage) begin
				stage = idle_stage;
				send_idle_pct = (stage == 1) ? 47 : 0;
				recv_idle_pct = (stage == 1) ? 9 : 0;
				write_mask(pick_mask(k++));
			end else if ($urandom_range(5) == 0) begin
				write_mask(pick_mask(k++));
			end
			send_block(1'b0);
		end

		term = $urandom_range(2);
		case (term)
			0: begin
				ending = "end address";
				send_word(16'($urandom_range(255)), 2);
				send_word(END_ADDRESS, 4);
			end
			1: begin
				ending = "checksum error";
				send_block(1'b1);
			end
			default: begin
				ending = "early tape end";
				repeat ($urandom_range(6))
					send_nibble(4'($urandom_range(15)));
				send_char(8'($urandom_range(255)), 1'b1, 1'b0);
			end
		endcase
		// Once the load is over everything is ignored, tape end included.
		repeat (16)
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);

		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d tape characters in %0d blocks, %0d memory writes, %0d mask settings.",
			items_sent, blocks_sent, writes_seen, masks_written);
		$display("The load was ended by %s; %0d mismatches.", ending, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ptbl_pkg.sv
rtl/ptbl_fifo.sv
rtl/ptbl_front.sv
rtl/ptbl_back.sv
rtl/paper_tape_block_loader.sv
tb/paper_tape_block_loader_test.sv
